// File: hdl/q6at_pkg.sv
// shared constants, types and functions for the quaternion to actuator block
// no dependencies
package q6at_pkg;

  localparam int QW = 16;
  localparam int HW = 8;
  localparam int MW = 12;
  localparam int BW = 18;
  localparam int TW = 17;
  localparam int SW = 22;
  // cordic datapath width: n2 <= 2^32, doubled terms < 2^33, growth ~1.65
  localparam int CW = 37;
  localparam int AW = 30;
  localparam int TAB_LEN = 24;
  localparam int ANG_FRAC = 20;
  localparam logic signed [AW-1:0] ANG_QUARTER = 30'sd94371840;
  localparam int CLAMP_MAX = 32000;
  // product of two 64-bit-safe values for isqrt: p,q < 2^34, (p>>2)*(q>>2) < 2^64
  localparam int RW = 64;

  typedef enum logic [1:0] {
    CFG_CLAMP_BYPASS = 2'd0,
    CFG_BASE_SPEED   = 2'd1,
    CFG_BASE_ACCEL   = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [AW-1:0] z;
  } cordic_t;

  function automatic logic signed [AW-1:0] atan_entry(input int i);
    logic signed [AW-1:0] r;
    unique case (i)
      0: r = 30'sd47185920;  1: r = 30'sd27855475;  2: r = 30'sd14718068;
      3: r = 30'sd7471121;   4: r = 30'sd3750058;   5: r = 30'sd1876857;
      6: r = 30'sd938658;    7: r = 30'sd469357;    8: r = 30'sd234682;
      9: r = 30'sd117342;    10: r = 30'sd58671;    11: r = 30'sd29335;
      12: r = 30'sd14668;    13: r = 30'sd7334;     14: r = 30'sd3667;
      15: r = 30'sd1833;     16: r = 30'sd917;      17: r = 30'sd458;
      18: r = 30'sd229;      19: r = 30'sd115;      20: r = 30'sd57;
      21: r = 30'sd29;       22: r = 30'sd14;       23: r = 30'sd7;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// File: hdl/q6at_if.sv
// valid/ready channel interfaces for input items, results and configuration
// depends on q6at_pkg
interface q6at_in_if;
  import q6at_pkg::*;
  logic valid;
  logic ready;
  logic signed [QW-1:0] quat_w;
  logic signed [QW-1:0] quat_x;
  logic signed [QW-1:0] quat_y;
  logic signed [QW-1:0] quat_z;
  logic signed [HW-1:0] height_mm;
  logic [MW-1:0] speed_mult;
  logic [MW-1:0] accel_mult;
  modport source (output valid, quat_w, quat_x, quat_y, quat_z, height_mm, speed_mult,
                  accel_mult, input ready);
  modport sink (input valid, quat_w, quat_x, quat_y, quat_z, height_mm, speed_mult,
                accel_mult, output ready);
endinterface

interface q6at_out_if;
  import q6at_pkg::*;
  logic valid;
  logic ready;
  logic signed [TW-1:0] target_1;
  logic signed [TW-1:0] target_2;
  logic signed [TW-1:0] target_3;
  logic signed [TW-1:0] target_4;
  logic signed [TW-1:0] target_5;
  logic signed [TW-1:0] target_6;
  logic [SW-1:0] move_speed;
  logic [SW-1:0] move_accel;
  logic status;
  modport source (output valid, target_1, target_2, target_3, target_4, target_5, target_6,
                  move_speed, move_accel, status, input ready);
  modport sink (input valid, target_1, target_2, target_3, target_4, target_5, target_6,
                move_speed, move_accel, status, output ready);
endinterface

interface q6at_cfg_if;
  logic valid;
  logic ready;
  logic [1:0] index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// File: hdl/quaternion_to_six_actuator_targets.sv
// Accepts one quaternion item per cycle while the output register is free or
// being taken, and returns one result per item, with the cordic stage
// count capped at 24. Each item passes a product stage, a sum stage, a radicand
// product stage, a 32-cell square-root chain and a pre-rotation stage. Next come
// CORDIC_STAGES cordic cells, run in parallel for roll, pitch and yaw, then
// rounding, and mixing into the output register. The whole pipeline advances when
// the output register is free or being taken, so throughput is one transaction
// per cycle.
// depends on q6at_pkg, q6at_if, q6at_sqrt_cell, q6at_cordic_cell
module quaternion_to_six_actuator_targets #(
  parameter int CORDIC_STAGES = 16
) (
  input logic clk_i,
  input logic rst_ni,
  q6at_in_if.sink    in_if,
  q6at_out_if.source out_if,
  q6at_cfg_if.sink   cfg_if
);
  import q6at_pkg::*;
  localparam int NC = (CORDIC_STAGES < TAB_LEN) ? CORDIC_STAGES : TAB_LEN;
  localparam int NS = RW / 2;
  localparam int DEPTH = 3 + NS + NC + 2;

  logic clamp_bypass_q;
  logic [BW-1:0] base_speed_q, base_accel_q;

  assign cfg_if.ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clamp_bypass_q <= 1'b0;
      base_speed_q <= BW'(48000);
      base_accel_q <= BW'(36000);
    end else if (cfg_if.valid) begin
      unique case (cfg_if.index)
        CFG_CLAMP_BYPASS: clamp_bypass_q <= cfg_if.data[0];
        CFG_BASE_SPEED:   base_speed_q <= cfg_if.data[BW-1:0];
        CFG_BASE_ACCEL:   base_accel_q <= cfg_if.data[BW-1:0];
        default: ;
      endcase
    end
  end

  logic en;
  logic [DEPTH-1:0] vld_q;
  assign en = !out_if.valid || out_if.ready;
  assign in_if.ready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q <= '0;
    else if (en) vld_q <= {vld_q[DEPTH-2:0], in_if.valid};
  end

  // side data travels with the item: height and multipliers
  typedef struct packed {
    logic signed [HW-1:0] h;
    logic [MW-1:0] sm;
    logic [MW-1:0] am;
  } side_t;
  side_t side_q [DEPTH];
  always_ff @(posedge clk_i) begin
    if (en) begin
      side_q[0] <= '{h: in_if.height_mm, sm: in_if.speed_mult, am: in_if.accel_mult};
      for (int k = 1; k < DEPTH; k++) side_q[k] <= side_q[k-1];
    end
  end

  // stage 0: products
  logic signed [31:0] ww_q, xx_q, yy_q, zz_q, wx_q, yz_q, wz_q, xy_q, wy_q, zx_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      ww_q <= in_if.quat_w * in_if.quat_w;  xx_q <= in_if.quat_x * in_if.quat_x;
      yy_q <= in_if.quat_y * in_if.quat_y;  zz_q <= in_if.quat_z * in_if.quat_z;
      wx_q <= in_if.quat_w * in_if.quat_x;  yz_q <= in_if.quat_y * in_if.quat_z;
      wz_q <= in_if.quat_w * in_if.quat_z;  xy_q <= in_if.quat_x * in_if.quat_y;
      wy_q <= in_if.quat_w * in_if.quat_y;  zx_q <= in_if.quat_z * in_if.quat_x;
    end
  end

  // stage 1: euler numerators and denominators at scale n2
  logic signed [CW-1:0] n2_q, ry_q, rx_q, yy1_q, yx_q, a_q;
  always_ff @(posedge clk_i) begin
    logic signed [CW-1:0] n2, a;
    n2 = CW'(ww_q) + CW'(xx_q) + CW'(yy_q) + CW'(zz_q);
    a = (CW'(wy_q) - CW'(zx_q)) <<< 1;
    if (en) begin
      n2_q <= n2;
      ry_q <= (CW'(wx_q) + CW'(yz_q)) <<< 1;
      rx_q <= n2 - ((CW'(xx_q) + CW'(yy_q)) <<< 1);
      yy1_q <= (CW'(wz_q) + CW'(xy_q)) <<< 1;
      yx_q <= n2 - ((CW'(yy_q) + CW'(zz_q)) <<< 1);
      if (a > n2) a_q <= n2;
      else if (a < -n2) a_q <= -n2;
      else a_q <= a;
    end
  end

  // stage 2: radicand product; p and q stay below 2^34, so each quarter fits 32 bits
  logic [RW-1:0] rad_q;
  always_ff @(posedge clk_i) begin
    logic [CW-1:0] p, q;
    p = CW'(n2_q - a_q);
    q = CW'(n2_q + a_q);
    if (en) rad_q <= RW'(p[33:2]) * RW'(q[33:2]);
  end

  // square root chain, with the angle arguments delayed alongside
  typedef struct packed {
    logic signed [CW-1:0] ry, rx, yy, yx, a, n2;
  } arg_t;
  arg_t arg_q [NS+1];
  always_ff @(posedge clk_i) begin
    if (en) begin
      arg_q[0] <= '{ry: ry_q, rx: rx_q, yy: yy1_q, yx: yx_q, a: a_q, n2: n2_q};
      for (int k = 1; k <= NS; k++) arg_q[k] <= arg_q[k-1];
    end
  end
  logic [RW-1:0] srem [NS+1];
  logic [RW-1:0] sres [NS+1];
  assign srem[0] = rad_q;
  assign sres[0] = '0;
  for (genvar g = 0; g < NS; g++) begin : g_sqrt
    q6at_sqrt_cell #(.Bit(NS - 1 - g)) u_cell (
      .clk_i, .en_i(en), .rem_i(srem[g]), .res_i(sres[g]),
      .rem_o(srem[g+1]), .res_o(sres[g+1]));
  end

  // pre-rotation into the right half plane
  function automatic cordic_t pre_rot(input logic signed [CW-1:0] y, x);
    cordic_t r;
    if (x[CW-1]) begin
      if (!y[CW-1]) begin r.x = y;  r.y = -x; r.z = ANG_QUARTER; end
      else begin r.x = -y; r.y = x; r.z = -ANG_QUARTER; end
    end else begin
      r.x = x; r.y = y; r.z = '0;
    end
    return r;
  endfunction

  cordic_t cr [3][NC+1];
  logic [2:0] zero_q [NC+1];
  logic nz_q [NC+1];
  always_ff @(posedge clk_i) begin
    logic signed [CW-1:0] b;
    b = CW'(sres[NS][CW-3:0]) <<< 2;
    if (en) begin
      cr[0][0] <= pre_rot(arg_q[NS].ry, arg_q[NS].rx);
      cr[1][0] <= pre_rot(arg_q[NS].a, b);
      cr[2][0] <= pre_rot(arg_q[NS].yy, arg_q[NS].yx);
      zero_q[0] <= {arg_q[NS].yy == 0 && arg_q[NS].yx == 0,
                    arg_q[NS].a == 0 && b == 0,
                    arg_q[NS].ry == 0 && arg_q[NS].rx == 0};
      nz_q[0] <= (arg_q[NS].n2 == 0);
      for (int k = 1; k <= NC; k++) begin
        zero_q[k] <= zero_q[k-1];
        nz_q[k] <= nz_q[k-1];
      end
    end
  end
  for (genvar c = 0; c < 3; c++) begin : g_ang
    for (genvar s = 0; s < NC; s++) begin : g_cell
      q6at_cordic_cell #(.Stage(s)) u_cell (
        .clk_i, .en_i(en), .d_i(cr[c][s]), .d_o(cr[c][s+1]));
    end
  end

  function automatic logic signed [9:0] to_deg(input logic signed [AW-1:0] z, input logic zr);
    logic [AW-1:0] mag;
    logic [9:0] r;
    mag = z[AW-1] ? AW'(-z) : AW'(z);
    r = 10'((mag + (AW'(1) << (ANG_FRAC - 1))) >> ANG_FRAC);
    if (zr) return '0;
    return z[AW-1] ? -$signed(r) : $signed(r);
  endfunction

  // rounding stage
  logic signed [9:0] roll_q, pitch_q, yaw_q;
  logic nz_r_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      roll_q <= to_deg(cr[0][NC].z, zero_q[NC][0]);
      pitch_q <= to_deg(cr[1][NC].z, zero_q[NC][1]);
      yaw_q <= to_deg(cr[2][NC].z, zero_q[NC][2]);
      nz_r_q <= nz_q[NC];
    end
  end

  function automatic logic signed [TW-1:0] fin(input logic signed [19:0] v, input logic byp);
    if (!byp) begin
      if (v < 0) return '0;
      if (v > CLAMP_MAX) return TW'(CLAMP_MAX);
    end
    return v[TW-1:0];
  endfunction

  // mixing and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_if.valid <= 1'b0;
    else if (en) out_if.valid <= vld_q[DEPTH-1];
  end
  always_ff @(posedge clk_i) begin
    logic signed [19:0] y10, p10, r10, hm;
    side_t sd;
    sd = side_q[DEPTH-1];
    y10 = 20'(yaw_q) * 20'sd10;
    p10 = 20'(pitch_q) * 20'sd10;
    r10 = 20'(roll_q) * 20'sd10;
    hm = 20'(sd.h) * 20'sd400;
    if (en) begin
      if (nz_r_q) begin
        out_if.target_1 <= '0; out_if.target_2 <= '0; out_if.target_3 <= '0;
        out_if.target_4 <= '0; out_if.target_5 <= '0; out_if.target_6 <= '0;
        out_if.move_speed <= '0; out_if.move_accel <= '0; out_if.status <= 1'b1;
      end else begin
        out_if.target_1 <= fin(-y10 + p10 + r10 + hm, clamp_bypass_q);
        out_if.target_2 <= fin(y10 - p10 - r10 + hm, clamp_bypass_q);
        out_if.target_3 <= fin(-y10 - p10 - r10 + hm, clamp_bypass_q);
        out_if.target_4 <= fin(y10 + p10 - r10 + hm, clamp_bypass_q);
        out_if.target_5 <= fin(-y10 + p10 - r10 + hm, clamp_bypass_q);
        out_if.target_6 <= fin(y10 - p10 + r10 + hm, clamp_bypass_q);
        out_if.move_speed <= SW'((30'(base_speed_q) * 30'(sd.sm)) >> 8);
        out_if.move_accel <= SW'((30'(base_accel_q) * 30'(sd.am)) >> 8);
        out_if.status <= 1'b0;
      end
    end
  end
endmodule

// File: hdl/q6at_sqrt_cell.sv
// one cell of the pipelined restoring square root, two radicand bits per cell
// depends on q6at_pkg
module q6at_sqrt_cell #(
  parameter int Bit = 0
) (
  input  logic                   clk_i,
  input  logic                   en_i,
  input  logic [q6at_pkg::RW-1:0] rem_i,
  input  logic [q6at_pkg::RW-1:0] res_i,
  output logic [q6at_pkg::RW-1:0] rem_o,
  output logic [q6at_pkg::RW-1:0] res_o
);
  import q6at_pkg::*;
  localparam logic [RW-1:0] BitVal = RW'(1) << (2 * Bit);
  logic [RW:0] sum;
  logic [RW-1:0] rem_q, res_q;

  assign sum = {1'b0, res_i} + {1'b0, BitVal};

  // one step of the restoring recurrence; the leading skip is harmless since bit>v never fires
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if ({1'b0, rem_i} >= sum) begin
        rem_q <= rem_i - sum[RW-1:0];
        res_q <= (res_i >> 1) + BitVal;
      end else begin
        rem_q <= rem_i;
        res_q <= res_i >> 1;
      end
    end
  end
  assign rem_o = rem_q;
  assign res_o = res_q;
endmodule

// File: hdl/q6at_cordic_cell.sv
// one vectoring cordic cell: shift-add rotation and angle update
// depends on q6at_pkg
module q6at_cordic_cell #(
  parameter int Stage = 0
) (
  input  logic              clk_i,
  input  logic              en_i,
  input  q6at_pkg::cordic_t d_i,
  output q6at_pkg::cordic_t d_o
);
  import q6at_pkg::*;
  cordic_t d_q, d_d;
  logic signed [CW-1:0] xs, ys;

  assign xs = d_i.x >>> Stage;
  assign ys = d_i.y >>> Stage;

  always_comb begin
    if (!d_i.y[CW-1]) begin
      d_d.x = d_i.x + ys;
      d_d.y = d_i.y - xs;
      d_d.z = d_i.z + atan_entry(Stage);
    end else begin
      d_d.x = d_i.x - ys;
      d_d.y = d_i.y + xs;
      d_d.z = d_i.z - atan_entry(Stage);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) d_q <= d_d;
  end
  assign d_o = d_q;
endmodule
